[src/tilt_complementary_servo_assert.svh]
// assertion macros shared by the tilt servo checker
`ifndef TILT_COMPLEMENTARY_SERVO_ASSERT_SVH
`define TILT_COMPLEMENTARY_SERVO_ASSERT_SVH

// antecedent in this cycle implies consequent in the next cycle
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcs check failed");

// antecedent implies consequent in the same cycle
`define TCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcs check failed");

`endif

[src/tcs_pkg.sv]
// ----------------------------------------------------------------------------
// tcs_pkg
// shared constants, types and the arctangent table of the tilt servo
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_XW        = 28;
    localparam int CORDIC_ZW        = 27;
    localparam int Z_HALF_TURN      = 180 * 65536;

    // 65536/131000 reduces to 8192/16375; reciprocals of 16375 scaled by 2^45 and 2^41
    localparam logic [13:0] GYRO_DIV_ODD  = 14'd16375;
    localparam logic [31:0] GYRO_RECIP_HI = 32'd2148663945;
    localparam logic [27:0] GYRO_RECIP_LO = 28'd134291497;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd4;

    localparam logic [7:0]  NEUTRAL_RST = 8'd90;
    localparam logic [11:0] GAIN_RST    = 12'd256;
    localparam logic [15:0] BLEND_RST   = 16'd62915;
    localparam logic [7:0]  MIN_RST     = 8'd0;
    localparam logic [7:0]  MAX_RST     = 8'd180;

    typedef struct packed {
        logic load;
        logic cordic_start;
        logic cordic_axis;
        logic div_start;
        logic axis;
        logic acc_cap;
        logic blend_mul;
        logic mix_wr;
        logic gain_mul;
        logic servo_wr;
        logic out_load;
    } tcs_cmd_t;

    typedef struct packed {
        logic cordic_busy;
        logic div_busy;
    } tcs_status_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[src/tcs_if.sv]
// ----------------------------------------------------------------------------
// tcs_sample_if / tcs_result_if
// valid/ready channels for raw samples and servo results
// ----------------------------------------------------------------------------
interface tcs_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic        [15:0] elapsed_ms;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms,
                  output ready);
    modport mon (input valid, ready, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms);
endinterface

interface tcs_result_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  servo_x_deg;
    logic        [7:0]  servo_y_deg;
    logic signed [23:0] tilt_x;
    logic signed [23:0] tilt_y;

    modport source (output valid, servo_x_deg, servo_y_deg, tilt_x, tilt_y, input ready);
    modport sink (input valid, servo_x_deg, servo_y_deg, tilt_x, tilt_y, output ready);
    modport mon (input valid, ready, servo_x_deg, servo_y_deg, tilt_x, tilt_y);
endinterface

[src/tcs_cordic.sv]
// ----------------------------------------------------------------------------
// tcs_cordic
// iterative vectoring cordic, atan2 in degrees with 16 fraction bits
// ----------------------------------------------------------------------------
module tcs_cordic
    import tcs_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [15:0]          y_in,
    input  logic signed [15:0]          x_in,
    output logic                        busy,
    output logic signed [CORDIC_ZW-1:0] z_out
);
    localparam int SW = $clog2(CORDIC_STEPS);

    logic                        busy_reg;
    logic                        zero_reg;
    logic [SW-1:0]               step_reg;
    logic signed [CORDIC_XW-1:0] x_reg;
    logic signed [CORDIC_XW-1:0] y_reg;
    logic signed [CORDIC_ZW-1:0] z_reg;

    logic signed [16:0]          xs;
    logic signed [16:0]          ys;
    logic signed [CORDIC_XW-1:0] dx;
    logic signed [CORDIC_XW-1:0] dy;
    logic signed [CORDIC_ZW-1:0] angle;
    logic signed [CORDIC_ZW-1:0] z_init;

    always_comb
    begin
        // left half plane is folded by a half turn
        if (x_in < 0)
        begin
            xs = -17'(x_in);
            ys = -17'(y_in);
            z_init = (y_in >= 0) ? CORDIC_ZW'(Z_HALF_TURN) : -CORDIC_ZW'(Z_HALF_TURN);
        end
        else
        begin
            xs = 17'(x_in);
            ys = 17'(y_in);
            z_init = '0;
        end
        dx    = y_reg >>> step_reg;
        dy    = x_reg >>> step_reg;
        angle = $signed({{(CORDIC_ZW-22){1'b0}}, atan_q16(5'(step_reg))});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == SW'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (x_in == 0) && (y_in == 0);
            x_reg    <= $signed({{(CORDIC_XW-25){xs[16]}}, xs, 8'h00});
            y_reg    <= $signed({{(CORDIC_XW-25){ys[16]}}, ys, 8'h00});
            z_reg    <= z_init;
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + angle;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - angle;
            end
        end
    end

    assign busy  = busy_reg;
    assign z_out = zero_reg ? '0 : z_reg;
endmodule

[src/tcs_gdiv.sv]
// ----------------------------------------------------------------------------
// tcs_gdiv
// reciprocal divider, signed rate*ms scaled by 65536 over 131000
// ----------------------------------------------------------------------------
module tcs_gdiv
    import tcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [30:0]        mag,
    input  logic               neg,
    output logic               busy,
    output logic signed [31:0] quo
);
    logic        busy_reg;
    logic [1:0]  cnt_reg;
    logic [30:0] mag_reg;
    logic        neg_reg;
    logic [62:0] p1_reg;
    logic [17:0] hi_reg;
    logic [13:0] rem_reg;
    logic [30:0] q_reg;

    logic [17:0] hi;
    logic [31:0] hi_mul;
    logic [31:0] rem_full;
    logic [41:0] p2;

    // mag*8192/16375 = hi*8192 + rem*8192/16375 with hi = mag/16375
    assign hi       = p1_reg[62:45];
    assign hi_mul   = 32'(hi) * 32'(GYRO_DIV_ODD);
    assign rem_full = 32'(mag_reg) - hi_mul;
    assign p2       = 42'(rem_reg) * 42'(GYRO_RECIP_LO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 2'd2)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= mag;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 2'd0)
                p1_reg <= 63'(mag_reg) * 63'(GYRO_RECIP_HI);
            else if (cnt_reg == 2'd1)
            begin
                hi_reg  <= hi;
                rem_reg <= rem_full[13:0];
            end
            else
                q_reg <= {hi_reg, 13'h0000} + 31'(p2[41:28]);
        end
    end

    assign busy = busy_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule

[src/tcs_datapath.sv]
// ----------------------------------------------------------------------------
// tcs_datapath
// sample registers, settings, shared cordic, dividers, blend and servo math
// ----------------------------------------------------------------------------
module tcs_datapath
    import tcs_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcs_cmd_t              cmd,
    output tcs_status_t           status,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic signed [15:0]    accel_x,
    input  logic signed [15:0]    accel_y,
    input  logic signed [15:0]    accel_z,
    input  logic signed [15:0]    gyro_x,
    input  logic signed [15:0]    gyro_y,
    input  logic [15:0]           elapsed_ms,
    output logic [7:0]            servo_x_deg,
    output logic [7:0]            servo_y_deg,
    output logic signed [23:0]    tilt_x,
    output logic signed [23:0]    tilt_y
);
    logic [7:0]  neutral_reg;
    logic [11:0] gain_reg;
    logic [15:0] blend_reg;
    logic [7:0]  min_reg;
    logic [7:0]  max_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [15:0]        ms_reg;

    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic signed [31:0] ang_x_reg, ang_y_reg;
    logic signed [51:0] bprod_reg;
    logic signed [44:0] gprod_reg;
    logic [7:0]         srv_x_reg, srv_y_reg;
    logic [7:0]         out_sx_reg, out_sy_reg;
    logic signed [23:0] out_tx_reg, out_ty_reg;

    logic signed [15:0]          cy_in;
    logic                        cordic_busy;
    logic signed [CORDIC_ZW-1:0] cordic_z;
    logic signed [32:0]          px, py;
    logic                        divx_busy, divy_busy;
    logic signed [31:0]          qx, qy;

    logic signed [31:0] kept, gstep, acc;
    logic signed [34:0] diff;
    logic signed [36:0] mix;
    logic signed [31:0] mix_sat;
    logic signed [44:0] gsum;
    logic signed [20:0] trunc;
    logic signed [22:0] cmd_val;
    logic [7:0]         servo_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_reg <= NEUTRAL_RST;
            gain_reg    <= GAIN_RST;
            blend_reg   <= BLEND_RST;
            min_reg     <= MIN_RST;
            max_reg     <= MAX_RST;
            ang_x_reg   <= '0;
            ang_y_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_NEUTRAL: neutral_reg <= cfg_data[7:0];
                    REG_GAIN:    gain_reg    <= cfg_data[11:0];
                    REG_BLEND:   blend_reg   <= cfg_data;
                    REG_MIN:     min_reg     <= cfg_data[7:0];
                    REG_MAX:     max_reg     <= cfg_data[7:0];
                    default:     ;
                endcase
            end
            if (cmd.mix_wr)
            begin
                if (cmd.axis)
                    ang_y_reg <= mix_sat;
                else
                    ang_x_reg <= mix_sat;
            end
        end
    end

    // cordic operands: x tilt from (ay, az), y tilt from (ax, az)
    assign cy_in = cmd.cordic_axis ? ax_reg : ay_reg;

    tcs_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cordic_start),
        .y_in  (cy_in),
        .x_in  (az_reg),
        .busy  (cordic_busy),
        .z_out (cordic_z)
    );

    assign px = gx_reg * $signed({1'b0, ms_reg});
    assign py = gy_reg * $signed({1'b0, ms_reg});

    tcs_gdiv u_divx (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .mag   (px[32] ? 31'(-px) : px[30:0]),
        .neg   (px[32]),
        .busy  (divx_busy),
        .quo   (qx)
    );

    tcs_gdiv u_divy (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .mag   (py[32] ? 31'(-py) : py[30:0]),
        .neg   (py[32]),
        .busy  (divy_busy),
        .quo   (qy)
    );

    assign status.cordic_busy = cordic_busy;
    assign status.div_busy    = divx_busy | divy_busy;

    always_comb
    begin
        kept  = cmd.axis ? ang_y_reg : ang_x_reg;
        gstep = cmd.axis ? qy : qx;
        acc   = cmd.axis ? acc_y_reg : acc_x_reg;
        // b*gyro + (1-b)*accel = b*(gyro - accel) + accel, the accel term is exact
        diff  = 35'(kept) + 35'(gstep) - 35'(acc);
        mix   = 37'($signed(bprod_reg[51:16])) + 37'(acc);
        if (mix[36:31] == 6'b000000 || mix[36:31] == 6'b111111)
            mix_sat = mix[31:0];
        else
            mix_sat = mix[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;

        // truncate toward zero on the divide by 2^24
        gsum    = gprod_reg + (gprod_reg[44] ? 45'sd16777215 : 45'sd0);
        trunc   = gsum[44:24];
        cmd_val = $signed({15'b0, neutral_reg}) - 23'(trunc);
        if (cmd_val < $signed({15'b0, min_reg}))
            servo_val = min_reg;
        else if (cmd_val > $signed({15'b0, max_reg}))
            servo_val = max_reg;
        else
            servo_val = cmd_val[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            ms_reg <= elapsed_ms;
        end
        if (cmd.acc_cap)
        begin
            if (cmd.axis)
                acc_y_reg <= 32'(cordic_z);
            else
                acc_x_reg <= 32'(cordic_z);
        end
        if (cmd.blend_mul)
            bprod_reg <= $signed({1'b0, blend_reg}) * diff;
        if (cmd.gain_mul)
            gprod_reg <= kept * $signed({1'b0, gain_reg});
        if (cmd.servo_wr)
        begin
            if (cmd.axis)
                srv_y_reg <= servo_val;
            else
                srv_x_reg <= servo_val;
        end
        if (cmd.out_load)
        begin
            out_sx_reg <= srv_x_reg;
            out_sy_reg <= srv_y_reg;
            out_tx_reg <= ang_x_reg[31:8];
            out_ty_reg <= ang_y_reg[31:8];
        end
    end

    assign servo_x_deg = out_sx_reg;
    assign servo_y_deg = out_sy_reg;
    assign tilt_x      = out_tx_reg;
    assign tilt_y      = out_ty_reg;
endmodule

[src/tcs_ctrl.sv]
// ----------------------------------------------------------------------------
// tcs_ctrl
// sequencer for one sample: two atan2 runs, blend and servo per axis
// ----------------------------------------------------------------------------
module tcs_ctrl
    import tcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  tcs_status_t status,
    output tcs_cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CX, S_CY, S_BMX, S_MIXX, S_BMY, S_MIXY,
        S_GMX, S_SRVX, S_GMY, S_SRVY, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.cordic_start = 1'b1;
                cmd.div_start    = 1'b1;
                state_next       = S_CX;
            end
            S_CX:
            begin
                // capture the x tilt while the y run starts
                if (!status.cordic_busy)
                begin
                    cmd.acc_cap      = 1'b1;
                    cmd.cordic_axis  = 1'b1;
                    cmd.cordic_start = 1'b1;
                    state_next       = S_CY;
                end
            end
            S_CY:
            begin
                if (!status.cordic_busy && !status.div_busy)
                begin
                    cmd.acc_cap = 1'b1;
                    cmd.axis    = 1'b1;
                    state_next  = S_BMX;
                end
            end
            S_BMX:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = S_MIXX;
            end
            S_MIXX:
            begin
                cmd.mix_wr = 1'b1;
                state_next = S_BMY;
            end
            S_BMY:
            begin
                cmd.axis      = 1'b1;
                cmd.blend_mul = 1'b1;
                state_next    = S_MIXY;
            end
            S_MIXY:
            begin
                cmd.axis   = 1'b1;
                cmd.mix_wr = 1'b1;
                state_next = S_GMX;
            end
            S_GMX:
            begin
                cmd.gain_mul = 1'b1;
                state_next   = S_SRVX;
            end
            S_SRVX:
            begin
                cmd.servo_wr = 1'b1;
                state_next   = S_GMY;
            end
            S_GMY:
            begin
                cmd.axis     = 1'b1;
                cmd.gain_mul = 1'b1;
                state_next   = S_SRVY;
            end
            S_SRVY:
            begin
                cmd.axis     = 1'b1;
                cmd.servo_wr = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to drain
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

[src/tilt_complementary_servo.sv]
// ----------------------------------------------------------------------------
// tilt_complementary_servo
// two-axis complementary tilt filter with servo command outputs
// ----------------------------------------------------------------------------
// One sample is processed at a time: a new sample is taken only after the
// sequencer has loaded the previous result into the output register and
// returned to idle. The two atan2 runs share one iterative cordic unit, one
// step per cycle, while the gyro scaling dividers run alongside; blend and
// servo math then follow, first a blend multiply and a mix write per axis,
// then a gain multiply and a servo write per axis. A finished result sits in
// an output register; if the previous result is still held there, the
// sequencer waits and the input stays stalled until it is taken.
// ----------------------------------------------------------------------------
module tilt_complementary_servo
    import tcs_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    tcs_sample_if.sink            sample,
    tcs_result_if.source          result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    tcs_cmd_t    cmd;
    tcs_status_t status;

    tcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcs_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accel_x     (sample.accel_x),
        .accel_y     (sample.accel_y),
        .accel_z     (sample.accel_z),
        .gyro_x      (sample.gyro_x),
        .gyro_y      (sample.gyro_y),
        .elapsed_ms  (sample.elapsed_ms),
        .servo_x_deg (result.servo_x_deg),
        .servo_y_deg (result.servo_y_deg),
        .tilt_x      (result.tilt_x),
        .tilt_y      (result.tilt_y)
    );
endmodule

[src/tcs_checker.sv]
// ----------------------------------------------------------------------------
// tcs_checker
// port-level checks of the tilt servo, bound to the top level
// ----------------------------------------------------------------------------
`include "tilt_complementary_servo_assert.svh"

module tcs_checker (
    input logic          clk,
    input logic          rst_n,
    tcs_sample_if.sink   sample,
    tcs_result_if.source result
);
    // a stalled result keeps its x tilt and x servo payload
    `TCS_ASSERT_NEXT(a_out_hold, clk, rst_n, result.valid && !result.ready, result.valid && $stable(result.tilt_x) && $stable(result.servo_x_deg))

    // one sample at a time: no second transaction right after one
    `TCS_ASSERT_NEXT(a_in_busy, clk, rst_n, sample.valid && sample.ready, !sample.ready)

    // a new result only appears at the end of processing
    `TCS_ASSERT_SAME(a_out_rise, clk, rst_n, $rose(result.valid), $past(!sample.ready))
endmodule

bind tilt_complementary_servo tcs_checker u_tcs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (sample),
    .result (result)
);
